// ===== hw/rtl/pprq_pkg.sv =====
// Shared constants, types and compare function for the ready queue.
`timescale 1ns / 1ps
package pprq_pkg;
	localparam int DEPTH     = 64;
	localparam int ID_BITS   = 8;
	localparam int TIME_BITS = 32;
	localparam int PRIO_BITS = 8;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int OCC_W     = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [PRIO_BITS-1:0] prio;
		logic [TIME_BITS-1:0] last_run;
		logic [TIME_BITS-1:0] arrival;
	} entry_t;

	typedef struct packed {
		logic cap;
		logic do_push;
		logic scan_init;
		logic scan_run;
		logic shift_init;
		logic shift_run;
		logic occ_dec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       occ_zero;
		logic       scan_done;
		logic       shift_done;
		logic       out_free;
	} sts_t;

	// challenger (later slot) strictly beats incumbent
	function automatic logic beats(entry_t c, entry_t b);
		if (c.prio != b.prio) begin
			return c.prio > b.prio;
		end
		if (c.last_run != b.last_run) begin
			return c.last_run < b.last_run;
		end
		return c.arrival < b.arrival;
	endfunction
endpackage

// ===== hw/rtl/preemptive_priority_ready_queue.sv =====
// Top level of the preemptive priority ready queue.
// Input channel (in_valid/in_stall) takes one request: push, pop or check.
// Output channel (out_valid/out_stall) returns exactly one result per request.
// Tasks sit compacted in insert order in a 64-entry memory (one read, one
// write port, registered read data).
// Push: the entry is written at accept; the request then goes straight to the result state.
// Check: with a running task and a non-empty queue, a scan over all waiting
//   tasks, one memory read per cycle.
// Pop: on a non-empty queue the same scan, then the later entries move down
//   one slot per cycle.
// A request is taken only while the sequencer is idle; the result register
// decouples the two sides, so a new request is accepted while a result waits.
// If the receiver stalls, the finished result is held stable; the next
// request's result waits in the sequencer until the register frees.
// Reset empties the queue and clears the insert order; no clearing pass.
`timescale 1ns / 1ps
module preemptive_priority_ready_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [31:0] task_last_run,
	input  logic [31:0] task_arrival,
	input  logic        running_present,
	input  logic [7:0]  running_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [7:0]  out_id,
	output logic [7:0]  out_priority,
	output logic [31:0] out_last_run,
	output logic [31:0] out_arrival,
	output logic        reschedule,
	output logic        overflow,
	output logic        queue_empty
);
	import pprq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pprq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.running_present (running_present),
		.sts             (sts),
		.cmd             (cmd)
	);

	pprq_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (operation),
		.task_id          (task_id),
		.task_priority    (task_priority),
		.task_last_run    (task_last_run),
		.task_arrival     (task_arrival),
		.running_present  (running_present),
		.running_priority (running_priority),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.found            (found),
		.out_id           (out_id),
		.out_priority     (out_priority),
		.out_last_run     (out_last_run),
		.out_arrival      (out_arrival),
		.reschedule       (reschedule),
		.overflow         (overflow),
		.queue_empty      (queue_empty)
	);
endmodule

// ===== hw/rtl/pprq_ctrl.sv =====
// Sequencer for push, scan, shift and result hand-off.
`timescale 1ns / 1ps
module pprq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    operation,
	input  logic          running_present,
	input  pprq_pkg::sts_t sts,
	output pprq_pkg::cmd_t cmd
);
	import pprq_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_RES   = 2'd3;

	logic [1:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_RES;
					if (operation == OP_PUSH) begin
						cmd.do_push = 1'b1;
					end else if (!sts.occ_zero && (operation == OP_POP ||
						(operation == OP_CHECK && running_present))) begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					if (sts.op == OP_POP) begin
						cmd.shift_init = 1'b1;
						state_d = S_SHIFT;
					end else begin
						state_d = S_RES;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_run = 1'b1;
				if (sts.shift_done) begin
					cmd.occ_dec = 1'b1;
					state_d = S_RES;
				end
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== hw/rtl/pprq_dp.sv =====
// Task store, best-task search, compaction and result register.
`timescale 1ns / 1ps
module pprq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pprq_pkg::cmd_t                cmd,
	output pprq_pkg::sts_t                sts,
	input  logic [1:0]                    operation,
	input  logic [pprq_pkg::ID_BITS-1:0]  task_id,
	input  logic [7:0]                    task_priority,
	input  logic [pprq_pkg::TIME_BITS-1:0] task_last_run,
	input  logic [pprq_pkg::TIME_BITS-1:0] task_arrival,
	input  logic                          running_present,
	input  logic [7:0]                    running_priority,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic                          found,
	output logic [7:0]                    out_id,
	output logic [7:0]                    out_priority,
	output logic [31:0]                   out_last_run,
	output logic [31:0]                   out_arrival,
	output logic                          reschedule,
	output logic                          overflow,
	output logic                          queue_empty
);
	import pprq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_s1, best_q;
	logic [IDX_W-1:0] raddr, idx_s1, best_idx_q;
	logic [OCC_W-1:0] occ_q, ptr_q;
	logic valid_s1, found_q, ovf_q, rp_q;
	logic [1:0] op_q;
	logic [7:0] rprio_q;
	logic issue;
	logic out_valid_q;

	assign issue = ptr_q < occ_q;
	assign raddr = ptr_q[IDX_W-1:0];

	assign sts.op         = op_q;
	assign sts.occ_zero   = (occ_q == '0);
	assign sts.scan_done  = !issue && !valid_s1;
	assign sts.shift_done = !issue && !valid_s1;
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[raddr];
		if (cmd.do_push && occ_q != OCC_W'(DEPTH)) begin
			mem[occ_q[IDX_W-1:0]] <= '{id: task_id, prio: task_priority,
				last_run: task_last_run, arrival: task_arrival};
		end else if (cmd.shift_run && valid_s1) begin
			mem[idx_s1] <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q    <= operation;
			rp_q    <= running_present;
			rprio_q <= running_priority;
			// a scan always starts together with the capture
			found_q <= cmd.scan_init;
			ovf_q   <= (operation == OP_PUSH) && (occ_q == OCC_W'(DEPTH));
		end
		if (cmd.scan_run && valid_s1) begin
			if (idx_s1 == '0 || beats(rd_s1, best_q)) begin
				best_q     <= rd_s1;
				best_idx_q <= idx_s1;
			end
		end
		if (cmd.scan_init) begin
			ptr_q <= '0;
		end else if (cmd.shift_init) begin
			ptr_q <= OCC_W'(best_idx_q) + 1'b1;
		end else if ((cmd.scan_run || cmd.shift_run) && issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.scan_run && issue) begin
			idx_s1 <= raddr;
		end else if (cmd.shift_run && issue) begin
			idx_s1 <= raddr - 1'b1;
		end
		if (cmd.load_out) begin
			found        <= found_q && op_q == OP_POP;
			out_id       <= (found_q && op_q == OP_POP) ? best_q.id : '0;
			out_priority <= (found_q && op_q == OP_POP) ? best_q.prio : '0;
			out_last_run <= (found_q && op_q == OP_POP) ? best_q.last_run : '0;
			out_arrival  <= (found_q && op_q == OP_POP) ? best_q.arrival : '0;
			reschedule   <= (op_q == OP_CHECK) &&
				(!rp_q || (found_q && best_q.prio > rprio_q));
			overflow     <= ovf_q;
			queue_empty  <= (occ_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_push && occ_q != OCC_W'(DEPTH)) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.occ_dec) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.scan_init || cmd.shift_init) begin
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= (cmd.scan_run || cmd.shift_run) && issue;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the preemptive priority ready queue.
`timescale 1ns / 1ps
module testbench;
	import pprq_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic        found;
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [31:0] last_run;
		logic [31:0] arrival;
		logic        reschedule;
		logic        overflow;
		logic        queue_empty;
	} sched_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] operation = OP_PUSH;
	logic [7:0] task_id = 0;
	logic [7:0] task_priority = 0;
	logic [31:0] task_last_run = 0;
	logic [31:0] task_arrival = 0;
	logic running_present = 0;
	logic [7:0] running_priority = 0;
	logic out_valid;
	logic out_stall = 0;
	logic found;
	logic [7:0] out_id;
	logic [7:0] out_priority;
	logic [31:0] out_last_run;
	logic [31:0] out_arrival;
	logic reschedule;
	logic overflow;
	logic queue_empty;

	preemptive_priority_ready_queue DUT (.*);

	// predictor state: tasks compacted in insert order
	entry_t ready_q[$];
	sched_result_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int stall_mode = 0;
	int gap_max = 0;
	int burst_left = 0;

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int best_index();
		int b = 0;
		for (int i = 1; i < ready_q.size(); i++) begin
			if (ready_q[i].prio != ready_q[b].prio) begin
				if (ready_q[i].prio > ready_q[b].prio) b = i;
			end else if (ready_q[i].last_run != ready_q[b].last_run) begin
				if (ready_q[i].last_run < ready_q[b].last_run) b = i;
			end else if (ready_q[i].arrival < ready_q[b].arrival) begin
				b = i;
			end
		end
		return b;
	endfunction

	function automatic sched_result_t schedule_step(logic [1:0] op, entry_t t, logic run_p,
			logic [7:0] run_prio);
		sched_result_t r = '{default: 0};
		int b;
		case (op)
			OP_PUSH: begin
				if (ready_q.size() >= DEPTH) r.overflow = 1;
				else ready_q.push_back(t);
			end
			OP_POP: begin
				if (ready_q.size() > 0) begin
					b = best_index();
					r.found = 1;
					r.id = ready_q[b].id;
					r.prio = ready_q[b].prio;
					r.last_run = ready_q[b].last_run;
					r.arrival = ready_q[b].arrival;
					ready_q.delete(b);
				end
			end
			OP_CHECK: begin
				if (!run_p) r.reschedule = 1;
				else if (ready_q.size() > 0)
					r.reschedule = ready_q[best_index()].prio > run_prio;
			end
			default: ;
		endcase
		r.queue_empty = ready_q.size() == 0;
		return r;
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ((cycles % 11) < 7);
		endcase
	end

	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (found !== e.found || out_id !== e.id || out_priority !== e.prio ||
						out_last_run !== e.last_run || out_arrival !== e.arrival ||
						reschedule !== e.reschedule || overflow !== e.overflow ||
						queue_empty !== e.queue_empty) begin
					$display("%0t: expected f%b id%h p%h lr%h ar%h rs%b ov%b em%b", $time,
						e.found, e.id, e.prio, e.last_run, e.arrival, e.reschedule,
						e.overflow, e.queue_empty);
					$display("%0t: actual   f%b id%h p%h lr%h ar%h rs%b ov%b em%b", $time,
						found, out_id, out_priority, out_last_run, out_arrival, reschedule,
						overflow, queue_empty);
					errors++;
				end
			end
		end
	end

	// one request; valid stays high across bursts and drops only for a gap
	task automatic send_request(logic [1:0] op, logic [7:0] id, logic [7:0] prio,
			logic [31:0] lr, logic [31:0] ar, logic rp, logic [7:0] rprio);
		entry_t t;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		operation <= op;
		task_id <= id;
		task_priority <= prio;
		task_last_run <= lr;
		task_arrival <= ar;
		running_present <= rp;
		running_priority <= rprio;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		t.id = id;
		t.prio = prio;
		t.last_run = lr;
		t.arrival = ar;
		expected_q.push_back(schedule_step(op, t, rp, rprio));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic push_task(logic [7:0] id, logic [7:0] prio, logic [31:0] lr, logic [31:0] ar);
		send_request(OP_PUSH, id, prio, lr, ar, $urandom, $urandom);
	endtask

	task automatic pop_task();
		send_request(OP_POP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic check_task(logic rp, logic [7:0] rprio);
		send_request(OP_CHECK, $urandom, $urandom, $urandom, $urandom, rp, rprio);
	endtask

	task automatic test_directed();
		pop_task();                      // pop on empty queue
		check_task(0, 8'h00);            // no running task, empty queue
		check_task(1, 8'h00);            // running task, empty queue
		send_request(OP_NONE, 8'hff, 8'hff, '1, '1, 1, 8'hff);
		push_task(8'h00, 8'h00, 32'h0, 32'h0);
		push_task(8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
		push_task(8'h11, 8'hff, 32'h0000_0010, 32'h5);
		push_task(8'h12, 8'hff, 32'h0000_0010, 32'h3);
		push_task(8'h13, 8'hff, 32'h0000_0010, 32'h3);   // full tie with previous
		check_task(1, 8'hff);
		check_task(1, 8'hfe);
		check_task(0, 8'hff);
		send_request(OP_NONE, 8'h0, 8'h0, 32'h0, 32'h0, 0, 8'h0);
		repeat (6) pop_task();
	endtask

	task automatic test_overflow();
		for (int i = 0; i < DEPTH + 3; i++)
			push_task($urandom, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
		check_task(1, 8'h02);
		repeat (DEPTH + 2) pop_task();
	endtask

	task automatic test_random(int n);
		int kind;
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				stall_mode = $urandom_range(0, 3);
				gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
			end
			kind = $urandom_range(0, 99);
			op = kind < 50 ? OP_PUSH : kind < 80 ? OP_POP : kind < 97 ? OP_CHECK : OP_NONE;
			if ($urandom_range(0, 1))
				send_request(op, $urandom, $urandom_range(0, 3), $urandom_range(0, 2),
					$urandom_range(0, 2), $urandom, $urandom_range(0, 4));
			else
				send_request(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_overflow();
		stall_mode = 1;
		gap_max = 3;
		test_random(1250);
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
